[rtl/ogfc_pkg.sv]
package ogfc_pkg;

  // Field and register widths fixed by the interface
  localparam int POS_W      = 24;
  localparam int CPM_W      = 16;
  localparam int DIM_W      = 9;
  localparam int RADCFG_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Coordinate conversion: d = pos - origin, p = d * cells_per_metre
  localparam int D_W    = POS_W + 1;
  localparam int P_W    = D_W + CPM_W + 1;
  localparam int FRAC_W = 16;
  localparam int CM_W   = P_W - FRAC_W;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_AREA  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_METRE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS   = 3'd5;

  localparam logic signed [7:0] OCC_THRESHOLD = 8'sd50;

  localparam logic [CPM_W-1:0]    RST_CELLS_PER_METRE = 16'd5120;
  localparam logic [DIM_W-1:0]    RST_MAP_WIDTH       = 9'd256;
  localparam logic [DIM_W-1:0]    RST_MAP_HEIGHT      = 9'd256;
  localparam logic [RADCFG_W-1:0] RST_WINDOW_RADIUS   = 4'd4;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [7:0]       cell_value;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } ogfc_in_t;

  typedef struct packed {
    logic occupied;
    logic out_of_bounds;
  } ogfc_out_t;

  // What the back end has to do with a classified item
  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_QUERY,
    JOB_DIRECT
  } ogfc_kind_t;

  typedef struct packed {
    ogfc_kind_t kind;
    logic       occ;
    logic       oob;
  } ogfc_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROWS,
    BK_DRAIN
  } ogfc_bk_state_t;

endpackage

[rtl/ogfc_front.sv]
module ogfc_front
  import ogfc_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int MAX_RADIUS  = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ogfc_in_t                      in_item,
  input  logic signed [POS_W-1:0]       origin_x,
  input  logic signed [POS_W-1:0]       origin_y,
  input  logic [CPM_W-1:0]              cells_per_metre,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0] eff_w,
  input  logic [$clog2(MAX_ROWS+1)-1:0]    eff_h,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]  radius,
  output logic                          job_valid,
  input  logic                          job_full,
  output ogfc_job_t                     job,
  output logic [$clog2(MAX_COLUMNS)-1:0] job_x0,
  output logic [$clog2(MAX_ROWS)-1:0]    job_y0,
  output logic [$clog2(MAX_RADIUS+1)-1:0] job_r
);

  localparam int XI_W  = $clog2(MAX_COLUMNS);
  localparam int YI_W  = $clog2(MAX_ROWS);
  localparam int RAD_W = $clog2(MAX_RADIUS+1);
  localparam int SUM_W = CM_W + 1;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;

  logic [1:0]            cmd1_r, cmd2_r, cmd3_r;
  logic                  occ1_r, occ2_r, occ3_r;
  logic signed [D_W-1:0] dx1_r, dy1_r;
  logic signed [P_W-1:0] px2_r, py2_r;
  logic                  negx3_r, negy3_r;
  logic [CM_W-1:0]       magx3_r, magy3_r;

  logic [P_W-1:0]   magx, magy;
  logic [RAD_W-1:0] r_use;
  logic             x_bad, y_bad;
  ogfc_job_t        job_nxt;

  ogfc_job_t        job4_r;
  logic [XI_W-1:0]  x04_r;
  logic [YI_W-1:0]  y04_r;
  logic [RAD_W-1:0] r4_r;

  // whole pipe holds while the last stage cannot hand off
  assign in_stall = v4_r && job_full;
  assign adv      = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // truncation toward zero: work on the magnitude, keep the sign apart
  assign magx = px2_r[P_W-1] ? (~px2_r + P_W'(1)) : px2_r;
  assign magy = py2_r[P_W-1] ? (~py2_r + P_W'(1)) : py2_r;

  always_comb begin
    r_use = (cmd3_r == CMD_AREA) ? radius : '0;
    x_bad = (negx3_r && (magx3_r != '0)) || (magx3_r < CM_W'(r_use)) ||
            ((SUM_W'(magx3_r) + SUM_W'(r_use)) >= SUM_W'(eff_w));
    y_bad = (negy3_r && (magy3_r != '0)) || (magy3_r < CM_W'(r_use)) ||
            ((SUM_W'(magy3_r) + SUM_W'(r_use)) >= SUM_W'(eff_h));
    job_nxt.kind = JOB_DIRECT;
    job_nxt.occ  = 1'b0;
    job_nxt.oob  = 1'b0;
    case (cmd3_r)
      CMD_LOAD: begin
        job_nxt.kind = JOB_LOAD;
        job_nxt.occ  = occ3_r;
      end
      CMD_POINT, CMD_AREA: begin
        if (x_bad || y_bad) begin
          job_nxt.occ = 1'b1;
          job_nxt.oob = 1'b1;
        end else begin
          job_nxt.kind = JOB_QUERY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= in_item.command;
      occ1_r  <= $signed(in_item.cell_value) > OCC_THRESHOLD;
      dx1_r   <= {in_item.pos_x[POS_W-1], in_item.pos_x} - {origin_x[POS_W-1], origin_x};
      dy1_r   <= {in_item.pos_y[POS_W-1], in_item.pos_y} - {origin_y[POS_W-1], origin_y};

      cmd2_r  <= cmd1_r;
      occ2_r  <= occ1_r;
      px2_r   <= dx1_r * $signed({1'b0, cells_per_metre});
      py2_r   <= dy1_r * $signed({1'b0, cells_per_metre});

      cmd3_r  <= cmd2_r;
      occ3_r  <= occ2_r;
      negx3_r <= px2_r[P_W-1];
      negy3_r <= py2_r[P_W-1];
      magx3_r <= magx[P_W-1:FRAC_W];
      magy3_r <= magy[P_W-1:FRAC_W];

      job4_r  <= job_nxt;
      x04_r   <= XI_W'(magx3_r - CM_W'(r_use));
      y04_r   <= YI_W'(magy3_r - CM_W'(r_use));
      r4_r    <= r_use;
    end
  end

  assign job_valid = v4_r;
  assign job       = job4_r;
  assign job_x0    = x04_r;
  assign job_y0    = y04_r;
  assign job_r     = r4_r;

endmodule

[rtl/ogfc_queue.sv]
module ogfc_queue
  import ogfc_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/ogfc_back.sv]
module ogfc_back
  import ogfc_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int MAX_RADIUS  = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_empty,
  output logic                            job_pop,
  input  ogfc_job_t                       job,
  input  logic [$clog2(MAX_COLUMNS)-1:0]  job_x0,
  input  logic [$clog2(MAX_ROWS)-1:0]     job_y0,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] job_r,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0] eff_w,
  input  logic [$clog2(MAX_COLUMNS*MAX_ROWS+1)-1:0] cells,
  output logic                            out_empty,
  input  logic                            out_pop,
  output ogfc_out_t                       out_item
);

  localparam int XI_W      = $clog2(MAX_COLUMNS);
  localparam int YI_W      = $clog2(MAX_ROWS);
  localparam int RAD_W     = $clog2(MAX_RADIUS+1);
  localparam int SPAN_W    = RAD_W + 1;
  localparam int GRID      = MAX_COLUMNS * MAX_ROWS;
  localparam int IDX_W     = $clog2(GRID);
  localparam int CELL_W    = $clog2(GRID+1);
  // a grid word holds at least one full window row
  localparam int WORD_LOG  = $clog2(2*MAX_RADIUS+2);
  localparam int WORD      = 1 << WORD_LOG;
  localparam int NUM_WORDS = (GRID + WORD - 1) / WORD + 1;
  localparam int WA_W      = $clog2(NUM_WORDS);

  logic [WORD-1:0] grid [NUM_WORDS];

  ogfc_bk_state_t state_r, state_nxt;

  logic              slot_free, emit, start, issue, do_load;
  ogfc_out_t         emit_item;
  logic              res_v_r;
  ogfc_out_t         res_r;

  logic [IDX_W-1:0]  load_idx_r;
  logic              ld_in_map;
  logic [IDX_W-1:0]  ld_idx;
  logic [CELL_W-1:0] ld_inc;
  logic [IDX_W-1:0]  ld_next;

  logic [XI_W-1:0]   x0_r;
  logic [YI_W-1:0]   yrow_r;
  logic [SPAN_W-1:0] left_r;
  logic [WORD-1:0]   mask_r;
  logic              acc_r;

  logic              m_v_r, rd_v_r;
  logic [IDX_W-1:0]  mul_nxt, mul_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [WA_W-1:0]   rd_wa;
  logic [WORD-1:0]   rd0_r, rd1_r;
  logic [WORD_LOG-1:0] off_r;
  logic [2*WORD-1:0] win;
  logic              hit;

  assign slot_free = !res_v_r || out_pop;

  // load pointer wraps at the current map size
  assign ld_in_map = CELL_W'(load_idx_r) < cells;
  assign ld_idx    = ld_in_map ? load_idx_r : '0;
  assign ld_inc    = CELL_W'(ld_idx) + CELL_W'(1);
  assign ld_next   = (ld_inc >= cells) ? '0 : IDX_W'(ld_inc);

  // row pipeline: multiply, read two words, extract the window bits
  assign mul_nxt = IDX_W'(yrow_r) * IDX_W'(eff_w);
  assign rd_addr = mul_r + IDX_W'(x0_r);
  assign rd_wa   = WA_W'(rd_addr >> WORD_LOG);
  assign win     = {rd1_r, rd0_r} >> off_r;
  assign hit     = |(win[WORD-1:0] & mask_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty && (job.kind == JOB_QUERY)) begin
          state_nxt = BK_ROWS;
        end
      end
      BK_ROWS: begin
        if (left_r == '0) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!m_v_r && !rd_v_r && slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    start     = 1'b0;
    issue     = 1'b0;
    do_load   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          case (job.kind)
            JOB_LOAD: begin
              if (slot_free) begin
                job_pop            = 1'b1;
                do_load            = 1'b1;
                emit               = 1'b1;
                emit_item.occupied = job.occ;
              end
            end
            JOB_QUERY: begin
              job_pop = 1'b1;
              start   = 1'b1;
            end
            JOB_DIRECT: begin
              if (slot_free) begin
                job_pop                 = 1'b1;
                emit                    = 1'b1;
                emit_item.occupied      = job.occ;
                emit_item.out_of_bounds = job.oob;
              end
            end
            default: ;
          endcase
        end
      end
      BK_ROWS: issue = 1'b1;
      BK_DRAIN: begin
        if (!m_v_r && !rd_v_r && slot_free) begin
          emit               = 1'b1;
          emit_item.occupied = acc_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      m_v_r      <= 1'b0;
      rd_v_r     <= 1'b0;
      res_v_r    <= 1'b0;
      load_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      m_v_r   <= issue;
      rd_v_r  <= m_v_r;
      if (emit) begin
        res_v_r <= 1'b1;
      end else if (out_pop) begin
        res_v_r <= 1'b0;
      end
      if (do_load) begin
        load_idx_r <= ld_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= emit_item;
    end
    if (start) begin
      x0_r   <= job_x0;
      yrow_r <= job_y0;
      left_r <= {job_r, 1'b0};
      mask_r <= ~({WORD{1'b1}} << {job_r, 1'b1});
    end else if (issue) begin
      yrow_r <= yrow_r + YI_W'(1);
      left_r <= left_r - SPAN_W'(1);
    end
    if (start) begin
      acc_r <= 1'b0;
    end else if (rd_v_r) begin
      acc_r <= acc_r | hit;
    end
    mul_r <= mul_nxt;
    off_r <= WORD_LOG'(rd_addr % WORD);
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      grid[WA_W'(ld_idx >> WORD_LOG)][WORD_LOG'(ld_idx % WORD)] <= job.occ;
    end
    rd0_r <= grid[rd_wa];
    rd1_r <= grid[rd_wa + WA_W'(1)];
  end

  assign out_empty = !res_v_r;
  assign out_item  = res_r;

endmodule

[rtl/occupancy_grid_footprint_check.sv]
// Results: a load, an off-map query or an unused command is answered straight from its
//   classification; an on-map query (r = 0 for a point) scans its grid window first.
// Throughput: one load per cycle unless the result side or a query scan stalls;
//   a query holds the back end while its read loop fetches one window row per cycle.
// Reset (synchronous, rst_n low): queues empty, load pointer 0, registers to defaults;
//   grid contents are undefined until loaded and get no clearing pass.
module occupancy_grid_footprint_check
  import ogfc_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int MAX_RADIUS  = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input side, looks like a queue write port
  input  logic                  push,
  output logic                  full,
  input  ogfc_in_t              in_data,
  // result side, looks like a queue read port
  output logic                  empty,
  input  logic                  pop,
  output ogfc_out_t             out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XI_W   = $clog2(MAX_COLUMNS);
  localparam int YI_W   = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS+1);
  localparam int ROW_W  = $clog2(MAX_ROWS+1);
  localparam int RAD_W  = $clog2(MAX_RADIUS+1);
  localparam int CELL_W = $clog2(MAX_COLUMNS*MAX_ROWS+1);
  localparam int JOB_W  = $bits(ogfc_job_t) + XI_W + YI_W + RAD_W;
  // job queue between classification and grid access
  localparam int QDEPTH = 4;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] origin_x_r, origin_y_r;
  logic [CPM_W-1:0]        cpm_r;
  logic [DIM_W-1:0]        map_width_r, map_height_r;
  logic [RADCFG_W-1:0]     radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      cpm_r        <= RST_CELLS_PER_METRE;
      map_width_r  <= RST_MAP_WIDTH;
      map_height_r <= RST_MAP_HEIGHT;
      radius_r     <= RST_WINDOW_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:        origin_x_r   <= cfg_data;
        REG_ORIGIN_Y:        origin_y_r   <= cfg_data;
        REG_CELLS_PER_METRE: cpm_r        <= cfg_data[CPM_W-1:0];
        REG_MAP_WIDTH:       map_width_r  <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT:      map_height_r <= cfg_data[DIM_W-1:0];
        REG_WINDOW_RADIUS:   radius_r     <= cfg_data[RADCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective map size and radius: zero size acts as one, large values clamp
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [RAD_W-1:0]  eff_r;
  logic [CELL_W-1:0] cells_nxt, cells_r;

  always_comb begin
    if (map_width_r == '0) begin
      eff_w = COL_W'(1);
    end else if (32'(map_width_r) > MAX_COLUMNS) begin
      eff_w = COL_W'(MAX_COLUMNS);
    end else begin
      eff_w = COL_W'(map_width_r);
    end
    if (map_height_r == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(map_height_r) > MAX_ROWS) begin
      eff_h = ROW_W'(MAX_ROWS);
    end else begin
      eff_h = ROW_W'(map_height_r);
    end
    if (32'(radius_r) > MAX_RADIUS) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = RAD_W'(radius_r);
    end
  end

  // cell count only feeds the load pointer wrap, several stages downstream
  assign cells_nxt = CELL_W'(eff_w) * CELL_W'(eff_h);

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
  end

  // ---------------------------------------------------------------------------
  // Front end: coordinate conversion, bounds check, classification
  // ---------------------------------------------------------------------------
  logic             f_valid;
  logic             q_full;
  ogfc_job_t        f_job;
  logic [XI_W-1:0]  f_x0;
  logic [YI_W-1:0]  f_y0;
  logic [RAD_W-1:0] f_r;

  ogfc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_RADIUS  (MAX_RADIUS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (push),
    .in_stall        (full),
    .in_item         (in_data),
    .origin_x        (origin_x_r),
    .origin_y        (origin_y_r),
    .cells_per_metre (cpm_r),
    .eff_w           (eff_w),
    .eff_h           (eff_h),
    .radius          (eff_r),
    .job_valid       (f_valid),
    .job_full        (q_full),
    .job             (f_job),
    .job_x0          (f_x0),
    .job_y0          (f_y0),
    .job_r           (f_r)
  );

  // ---------------------------------------------------------------------------
  // Job queue: lets the front keep converting while the back scans a window
  // ---------------------------------------------------------------------------
  logic [JOB_W-1:0] q_wdata, q_rdata;
  logic             q_empty, q_pop;
  ogfc_job_t        b_job;
  logic [XI_W-1:0]  b_x0;
  logic [YI_W-1:0]  b_y0;
  logic [RAD_W-1:0] b_r;

  assign q_wdata = {f_job, f_x0, f_y0, f_r};
  assign {b_job, b_x0, b_y0, b_r} = q_rdata;

  ogfc_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // ---------------------------------------------------------------------------
  // Back end: grid writes, window scan, result register
  // ---------------------------------------------------------------------------
  ogfc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_RADIUS  (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .job       (b_job),
    .job_x0    (b_x0),
    .job_y0    (b_y0),
    .job_r     (b_r),
    .eff_w     (eff_w),
    .cells     (cells_r),
    .out_empty (empty),
    .out_pop   (pop),
    .out_item  (out_data)
  );

endmodule

[rtl/ogfc_checker.sv]
module ogfc_checker
  import ogfc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input ogfc_out_t out_data
);

  // items taken in whose results have not yet been transferred out
  logic [7:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (pending_r != 8'd0))
    else $error("result shown with no item outstanding");

  a_bounded_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 8'd16)
    else $error("more items in flight than the buffering holds");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed before transfer");

endmodule

bind occupancy_grid_footprint_check ogfc_checker u_ogfc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ogfc_pkg::*;

  localparam int GRID_COLS  = 256;
  localparam int GRID_ROWS  = 256;
  localparam int RADIUS_CAP = 15;
  localparam int LAT_CYCLES = 40;   // settle wait, sized for the worst query (radius 15)

  // Command 3 has no name in the package; the block ignores it.
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam longint POS_MAX = 64'sd8388607;
  localparam longint POS_MIN = -64'sd8388608;

  logic clk;
  logic rst_n = 1'b0;

  logic      push    = 1'b0;
  logic      full;
  ogfc_in_t  in_data = '0;
  logic      empty;
  logic      pop     = 1'b0;
  ogfc_out_t out_data;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  occupancy_grid_footprint_check #(
    .MAX_COLUMNS (GRID_COLS),
    .MAX_ROWS    (GRID_ROWS),
    .MAX_RADIUS  (RADIUS_CAP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("** occupancy_grid_footprint_check: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Register mirror. Only written while the block is idle, so the planner
  // (at queue time) and the predictor (at transfer time) see the same values.
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] org_x      = '0;
  logic signed [POS_W-1:0] org_y      = '0;
  logic [CPM_W-1:0]        cpm_reg    = RST_CELLS_PER_METRE;
  logic [DIM_W-1:0]        map_w_reg  = RST_MAP_WIDTH;
  logic [DIM_W-1:0]        map_h_reg  = RST_MAP_HEIGHT;
  logic [RADCFG_W-1:0]     radius_reg = RST_WINDOW_RADIUS;

  // Predicted grid contents and load pointer.
  bit occ_bits [GRID_COLS*GRID_ROWS];
  int grid_ptr = 0;

  // Planner view: which linear cells have been loaded by queued items.
  // Queries are only queued when every cell they read is already loaded.
  bit loaded [GRID_COLS*GRID_ROWS];
  int plan_ptr = 0;

  ogfc_in_t  cmd_q[$];       // items waiting for the driver
  ogfc_out_t verdict_q[$];   // expected occupancy verdicts, oldest first

  int n_issued = 0;
  int n_taken  = 0;
  int errors   = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int send_gap = 0;
  int take_gap = 0;

  int n_loads = 0, n_point = 0, n_area = 0, n_off = 0, n_nop = 0, n_phases = 0;

  // Size registers: 0 acts as 1, anything above the array size saturates.
  function automatic int span(input logic [DIM_W-1:0] v, input int cap);
    if (v == 0) return 1;
    return (int'(v) > cap) ? cap : int'(v);
  endfunction

  function automatic int eff_radius();
    return (int'(radius_reg) > RADIUS_CAP) ? RADIUS_CAP : int'(radius_reg);
  endfunction

  function automatic int map_cells();
    return span(map_w_reg, GRID_COLS) * span(map_h_reg, GRID_ROWS);
  endfunction

  // A load with the pointer past the current map lands on cell 0.
  function automatic int load_slot(input int ptr);
    return (ptr < map_cells()) ? ptr : 0;
  endfunction

  function automatic int after_slot(input int slot);
    return (slot + 1 >= map_cells()) ? 0 : slot + 1;
  endfunction

  // World position to cell index: (pos - origin) * cpm, 16 fraction bits,
  // truncated toward zero (so small negative offsets still land on cell 0).
  function automatic longint cell_index(input logic signed [POS_W-1:0] pos,
                                        input logic signed [POS_W-1:0] org);
    longint prod;
    prod = (longint'(pos) - longint'(org)) * longint'(cpm_reg);
    if (prod < 0) return -((-prod) >> 16);
    return prod >> 16;
  endfunction

  // Window of a query; returns 1 when any part of it is off the map.
  function automatic bit window_of(input ogfc_in_t it, output longint cx,
                                   output longint cy, output longint r);
    cx = cell_index(it.pos_x, org_x);
    cy = cell_index(it.pos_y, org_y);
    r  = (it.command == CMD_AREA) ? longint'(eff_radius()) : 0;
    return (cx - r < 0) || (cx + r >= longint'(span(map_w_reg, GRID_COLS))) ||
           (cy - r < 0) || (cy + r >= longint'(span(map_h_reg, GRID_ROWS)));
  endfunction

  function automatic bit reads_unloaded(input ogfc_in_t it);
    longint cx, cy, r;
    int     w;
    if (it.command != CMD_POINT && it.command != CMD_AREA) return 1'b0;
    if (window_of(it, cx, cy, r)) return 1'b0;   // off-map: no grid read
    w = span(map_w_reg, GRID_COLS);
    for (longint y = cy - r; y <= cy + r; y++)
      for (longint x = cx - r; x <= cx + r; x++)
        if (!loaded[y * w + x]) return 1'b1;
    return 1'b0;
  endfunction

  // Predictor: verdict for one transferred item, updating the grid copy.
  function automatic ogfc_out_t grid_verdict(input ogfc_in_t it);
    ogfc_out_t v;
    longint    cx, cy, r;
    int        w, slot;
    v = '0;
    w = span(map_w_reg, GRID_COLS);
    case (it.command)
      CMD_LOAD: begin
        slot = load_slot(grid_ptr);
        v.occupied = (it.cell_value > OCC_THRESHOLD);
        occ_bits[slot] = v.occupied;
        grid_ptr = after_slot(slot);
        n_loads++;
      end
      CMD_POINT, CMD_AREA: begin
        if (window_of(it, cx, cy, r)) begin
          v.occupied      = 1'b1;
          v.out_of_bounds = 1'b1;
          n_off++;
        end else begin
          for (longint y = cy - r; y <= cy + r; y++)
            for (longint x = cx - r; x <= cx + r; x++)
              if (occ_bits[y * w + x]) v.occupied = 1'b1;
        end
        if (it.command == CMD_POINT) n_point++;
        else n_area++;
      end
      default: n_nop++;
    endcase
    return v;
  endfunction

  // Queue one item and keep the planner's loaded map in step with it.
  function automatic void issue(input ogfc_in_t it);
    int slot;
    if (it.command == CMD_LOAD) begin
      slot = load_slot(plan_ptr);
      loaded[slot] = 1'b1;
      plan_ptr = after_slot(slot);
    end
    cmd_q.insert(cmd_q.size(), it);
    n_issued++;
  endfunction

  function automatic ogfc_in_t make_item(input logic [1:0] cmd,
                                         input logic signed [7:0] val,
                                         input logic [POS_W-1:0] px,
                                         input logic [POS_W-1:0] py);
    ogfc_in_t it;
    it.command    = cmd;
    it.cell_value = val;
    it.pos_x      = px;
    it.pos_y      = py;
    return it;
  endfunction

  // Mostly in-range occupancy values, some raw bytes over the full field.
  function automatic ogfc_in_t load_item();
    logic signed [7:0] val;
    if ($urandom_range(0, 3) == 0) val = 8'($urandom);
    else val = 8'($urandom_range(0, 101) - 1);
    return make_item(CMD_LOAD, val, 24'($urandom), 24'($urandom));
  endfunction

  // Position whose cell index lands near the target cell.
  function automatic logic [POS_W-1:0] aim(input longint target,
                                           input logic signed [POS_W-1:0] org);
    longint stride, d, p;
    stride = (cpm_reg == 0) ? 1 : longint'(cpm_reg);
    d = (target * 65536 + longint'($urandom_range(0, 65535))) / stride;
    p = longint'(org) + d;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    return p[POS_W-1:0];
  endfunction

  // Query aimed around the map edges and inside it; every fourth try uses
  // raw positions. Falls back to an ignored command if nothing is safe.
  function automatic ogfc_in_t aim_query(input logic [1:0] cmd);
    ogfc_in_t it;
    longint   w, h, r, tx, ty;
    w = span(map_w_reg, GRID_COLS);
    h = span(map_h_reg, GRID_ROWS);
    r = (cmd == CMD_AREA) ? longint'(eff_radius()) : 0;
    for (int k = 0; k < 40; k++) begin
      it = make_item(cmd, 8'($urandom), 24'($urandom), 24'($urandom));
      if (k % 4 != 3) begin
        tx = longint'($urandom_range(0, 32'(w + 2 * r + 5))) - (r + 3);
        ty = longint'($urandom_range(0, 32'(h + 2 * r + 5))) - (r + 3);
        it.pos_x = aim(tx, org_x);
        it.pos_y = aim(ty, org_y);
      end
      if (!reads_unloaded(it)) return it;
    end
    return make_item(CMD_NOP, 8'($urandom), 24'($urandom), 24'($urandom));
  endfunction

  function automatic void random_items(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)      issue(load_item());
      else if (sel < 60) issue(aim_query(CMD_POINT));
      else if (sel < 93) issue(aim_query(CMD_AREA));
      else issue(make_item(CMD_NOP, 8'($urandom), 24'($urandom), 24'($urandom)));
    end
  endfunction

  // Idle: every queued item transferred and every verdict checked, then let
  // the back end settle.
  task automatic wait_idle();
    while (n_taken != n_issued || verdict_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ORIGIN_X:        org_x      = val[POS_W-1:0];
      REG_ORIGIN_Y:        org_y      = val[POS_W-1:0];
      REG_CELLS_PER_METRE: cpm_reg    = val[CPM_W-1:0];
      REG_MAP_WIDTH:       map_w_reg  = val[DIM_W-1:0];
      REG_MAP_HEIGHT:      map_h_reg  = val[DIM_W-1:0];
      REG_WINDOW_RADIUS:   radius_reg = val[RADCFG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One map setting: reprogram while idle, optionally load the whole map in
  // row-major order (wrapping the pointer), then random traffic. With
  // hold_mid set the sender stops halfway until all verdicts are back.
  task automatic run_phase(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                           input logic [CPM_W-1:0] cpm, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h, input logic [RADCFG_W-1:0] r,
                           input bit fill, input int n, input int s_idle,
                           input int t_idle, input bit hold_mid);
    wait_idle();
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_CELLS_PER_METRE, CFG_DATA_W'(cpm));
    write_reg(REG_MAP_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_MAP_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(r));
    send_idle_pct = s_idle;
    take_idle_pct = t_idle;
    n_phases++;
    if (fill) repeat (map_cells()) issue(load_item());
    random_items(n / 2);
    if (hold_mid) wait_idle();
    random_items(n - n / 2);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one item per transfer, with random send gaps.
  // Transfer = push high and full low at the edge; the verdict is predicted
  // right there from the item that was on in_data.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        verdict_q.insert(verdict_q.size(), grid_verdict(in_data));
        n_taken++;
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          push <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 8);
          push <= 1'b0;
        end else begin
          in_data <= cmd_q.pop_front();
          push    <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each transferred result against the oldest verdict,
  // with random pop stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : take_results
    ogfc_out_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: result occ=%b oob=%b with nothing expected", $realtime,
                     out_data.occupied, out_data.out_of_bounds);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.occupied !== want.occupied ||
              out_data.out_of_bounds !== want.out_of_bounds) begin
            if (errors < 10)
              $display("%0t: mismatch occ exp %b got %b, oob exp %b got %b", $realtime,
                       want.occupied, out_data.occupied,
                       want.out_of_bounds, out_data.out_of_bounds);
            errors++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else if (take_idle_pct != 0 && $urandom_range(0, 99) < take_idle_pct) begin
        take_gap = $urandom_range(0, 8);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [POS_W-1:0]    rox, roy;
    logic [CPM_W-1:0]    rcpm;
    logic [DIM_W-1:0]    rw, rh;
    logic [RADCFG_W-1:0] rr;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    take_idle_pct = 20;

    // Reset settings: 256x256, 20 cells per metre, radius 4, origin 0.
    // Loads spanning the value field put cells 0..6 of row 0 around the
    // threshold (50 stays free, 51 is occupied).
    issue(make_item(CMD_LOAD, -8'sd128, 24'($urandom), 24'($urandom)));
    issue(make_item(CMD_LOAD, -8'sd1, 24'($urandom), 24'($urandom)));
    issue(make_item(CMD_LOAD, 8'sd0, 24'($urandom), 24'($urandom)));
    issue(make_item(CMD_LOAD, 8'sd50, 24'($urandom), 24'($urandom)));
    issue(make_item(CMD_LOAD, 8'sd51, 24'($urandom), 24'($urandom)));
    issue(make_item(CMD_LOAD, 8'sd100, 24'($urandom), 24'($urandom)));
    issue(make_item(CMD_LOAD, 8'sd127, 24'($urandom), 24'($urandom)));
    // read each of them back (13 position units step about one cell)
    for (int k = 0; k < 7; k++)
      issue(make_item(CMD_POINT, 8'($urandom), 24'(13 * k), 24'd12));
    // small negative offset truncates to cell 0, still on the map
    issue(make_item(CMD_POINT, 8'($urandom), 24'hFFFFFF, 24'hFFFFFF));
    // just off the left edge and just past the right edge
    issue(make_item(CMD_POINT, 8'($urandom), -24'sd13, 24'd0));
    issue(make_item(CMD_POINT, 8'($urandom), 24'd3277, 24'd0));
    // position extremes
    issue(make_item(CMD_POINT, 8'($urandom), 24'h7FFFFF, 24'h800000));
    // footprint around cell (3,0) pokes above the map; far-off footprint
    issue(make_item(CMD_AREA, 8'($urandom), 24'd39, 24'd6));
    issue(make_item(CMD_AREA, 8'($urandom), 24'h800000, 24'h7FFFFF));
    // ignored command
    issue(make_item(CMD_NOP, -8'sd1, 24'hFFFFFF, 24'hFFFFFF));
    issue(make_item(CMD_NOP, 8'($urandom), 24'($urandom), 24'($urandom)));

    // small map, one cell per metre, 3x3 footprint
    run_phase(24'd0, 24'd0, 16'd256, 9'd8, 9'd6, 4'd1, 1'b1, 60, 20, 20, 1'b0);
    // single-cell map, origin extremes, finest resolution, radius 0;
    // the old pointer lies past the map so the first load goes to cell 0
    run_phase(24'h800000, 24'h7FFFFF, 16'hFFFF, 9'd1, 9'd1, 4'd0, 1'b1, 30, 0, 40, 1'b0);
    // 12x11 map (width x height), 11x11 footprint; sender drains halfway
    run_phase(24'hFFF000, 24'h000800, 16'd1000, 9'd12, 9'd11, 4'd5, 1'b1, 80, 30, 0,
              1'b1);
    // width above the array saturates, height 0 acts as 1, largest radius,
    // coarsest resolution so raw positions often land on the map
    run_phase(24'd0, 24'd0, 16'd1, 9'd511, 9'd0, 4'd15, 1'b0, 60, 15, 15, 1'b0);
    // one column, height saturates to 256 rows
    run_phase(24'($urandom_range(0, 4095)), 24'($urandom_range(0, 4095)), 16'd20000,
              9'd0, 9'd300, 4'd2, 1'b0, 50, 40, 40, 1'b0);

    // two random small settings
    repeat (2) begin
      rox  = 24'(int'($urandom_range(0, 2097151)) - 1048576);
      roy  = 24'(int'($urandom_range(0, 2097151)) - 1048576);
      rcpm = 16'($urandom_range(256, 8192));
      rw   = 9'($urandom_range(1, 8));
      rh   = 9'($urandom_range(1, 8));
      rr   = 4'($urandom_range(0, 6));
      run_phase(rox, roy, rcpm, rw, rh, rr, 1'b1, 40, $urandom_range(5, 30),
                $urandom_range(5, 30), 1'b0);
    end

    // closing stretch at full rate on both sides
    run_phase(-24'sd2560, 24'd1280, 16'd1024, 9'd10, 9'd9, 4'd3, 1'b1, 60, 0, 0, 1'b0);

    wait_idle();
    $display("Covered %0d loads, %0d point and %0d footprint queries (%0d off the map),",
             n_loads, n_point, n_area, n_off);
    $display("%0d ignored commands, over %0d register settings; %0d mismatches.",
             n_nop, n_phases + 1, errors);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("** occupancy_grid_footprint_check: PASSED **");
    end else begin
      $display("** occupancy_grid_footprint_check: FAILED **");
    end
    $finish;
  end

endmodule
